[src/snfh_pkg.sv]
// snfh_pkg: shared types and codes for the serial node frame handler
// no dependencies; used by serial_node_frame_handler
package snfh_pkg;

   // transaction operation codes
   localparam logic [1:0] OP_RX_BYTE    = 2'd0;
   localparam logic [1:0] OP_HOST_WRITE = 2'd1;
   localparam logic [1:0] OP_HOST_READ  = 2'd2;
   localparam logic [1:0] OP_UNUSED     = 2'd3;

   // result kinds
   localparam logic [1:0] KIND_TX_BYTE   = 2'd0;
   localparam logic [1:0] KIND_READ_DATA = 2'd1;
   localparam logic [1:0] KIND_SET_EVENT = 2'd2;
   localparam logic [1:0] KIND_WR_STATUS = 2'd3;

   // control register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_NODE_ADDRESS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_CODE   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_END_CODE     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ESCAPE_CODE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SET_CMD      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_POLL_CMD     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_REPLY_CMD    = 3'd6;

   // fixed protocol bytes
   localparam logic [7:0] PREAMBLE_BYTE = 8'hFF;
   localparam logic [7:0] ADDR_BASE     = 8'd65;

   // reply header: two preamble bytes, start, address, reply command
   localparam int HDR_W = 3;
   localparam logic [HDR_W-1:0] HDR_PRE1  = 3'd0;
   localparam logic [HDR_W-1:0] HDR_PRE2  = 3'd1;
   localparam logic [HDR_W-1:0] HDR_START = 3'd2;
   localparam logic [HDR_W-1:0] HDR_ADDR  = 3'd3;
   localparam logic [HDR_W-1:0] HDR_REPLY = 3'd4;

   // frame parser modes
   typedef enum logic [3:0] {
      PM_PRE1,
      PM_PRE2,
      PM_PRE3,
      PM_ADDR,
      PM_CMD,
      PM_SKIPCMD,
      PM_DATA,
      PM_DATA_ESC,
      PM_SKIP,
      PM_SKIP_ESC,
      PM_AFTER_OTHER
   } parse_mode_type;

   // transaction sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RDWAIT,
      ST_HDR,
      ST_DATA,
      ST_END
   } seq_state_type;

endpackage

[src/serial_node_frame_handler.sv]
// serial_node_frame_handler: frame parser, host store access and poll reply streamer
// depends on snfh_pkg; output and input stores are local synchronous memories
//
// channel   direction  ports                                  handshake
// req_      in         operation, data_byte, store_index      valid/ready
// rsp_      out        result_kind, result_byte, write_acc.   valid/ready
// csr_      in         wr_en, index, wdata                    write only
//
// received byte or host write loads the result directly; host read first passes the
// output store read port and ST_RDWAIT; poll reply: five header bytes, then one result
// per input store byte plus one per escape, then the end code, all held by a stalled rsp_
// reset clears parser, sequencer and the per-entry valid bits at once; no clearing pass
// a stalled rsp_ holds the sequencer; req_ is taken only when idle and rsp_ can load
module serial_node_frame_handler #(
   parameter int RX_BYTES = 16,
   parameter int TX_BYTES = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   // input channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_operation,
   input  logic [7:0]                    req_data_byte,
   input  logic [7:0]                    req_store_index,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_result_kind,
   output logic [7:0]                    rsp_result_byte,
   output logic                          rsp_write_accepted,
   output logic                          rsp_last_of_run,
   // control registers
   input  logic                          csr_wr_en,
   input  logic [snfh_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]                    csr_wdata
);

   localparam int RX_AW = (RX_BYTES > 1) ? $clog2(RX_BYTES) : 1;
   localparam int TX_AW = (TX_BYTES > 1) ? $clog2(TX_BYTES) : 1;
   localparam int RI_W  = $clog2(RX_BYTES + 1);
   localparam logic [7:0]       RX_LIMIT = 8'(RX_BYTES);
   localparam logic [7:0]       TX_LIMIT = 8'(TX_BYTES);
   localparam logic [RI_W-1:0]  RI_LIMIT = RI_W'(RX_BYTES);
   localparam logic [TX_AW-1:0] TX_LAST  = TX_AW'(TX_BYTES - 1);

   // control registers
   logic [6:0] node_ff;
   logic [7:0] start_ff, end_ff, esc_ff, set_cmd_ff, poll_cmd_ff, reply_cmd_ff;

   // sequencer and parser state
   snfh_pkg::seq_state_type  seq_ff, seq_in;
   snfh_pkg::parse_mode_type mode_ff, mode_in;
   logic [RI_W-1:0]          rcv_idx_ff, rcv_idx_in;
   logic [snfh_pkg::HDR_W-1:0] hdr_ff, hdr_in;
   logic [TX_AW-1:0]         tx_idx_ff, tx_idx_in;
   logic                     esc_done_ff, esc_done_in;

   // result register
   logic       rsp_valid_ff;
   logic [1:0] rsp_kind_ff;
   logic [7:0] rsp_byte_ff;
   logic       rsp_acc_ff, rsp_last_ff;
   logic       out_load, out_free;
   logic [1:0] out_kind;
   logic [7:0] out_byte;
   logic       out_acc, out_last;

   // output store (written by set frames, read by host)
   logic [7:0]       out_mem [RX_BYTES];
   logic [RX_BYTES-1:0] out_vld_ff;
   logic             out_wr_en, out_rd_en;
   logic [RX_AW-1:0] out_wr_addr, out_rd_addr;
   logic [7:0]       out_rd_ff;
   logic             out_rd_ok_ff;

   // input store (written by host, read by reply)
   logic [7:0]       in_mem [TX_BYTES];
   logic [TX_BYTES-1:0] in_vld_ff;
   logic             in_wr_en, in_rd_en;
   logic [TX_AW-1:0] in_wr_addr, in_rd_addr;
   logic [7:0]       in_rd_ff;
   logic             in_rd_ok_ff;

   logic       req_fire;
   logic [7:0] addr_char;
   logic [7:0] tx_byte;
   logic       need_esc;
   logic       ev_set, ev_poll;
   logic       host_in_range;

   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (seq_ff == snfh_pkg::ST_IDLE) && out_free;
   assign addr_char = snfh_pkg::ADDR_BASE + {1'b0, node_ff};
   assign tx_byte   = in_rd_ok_ff ? in_rd_ff : 8'd0;
   assign need_esc  = ((tx_byte == end_ff) || (tx_byte == esc_ff)) && !esc_done_ff;

   // control register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         node_ff      <= 7'd0;
         start_ff     <= 8'd2;
         end_ff       <= 8'd3;
         esc_ff       <= 8'd16;
         set_cmd_ff   <= 8'd84;
         poll_cmd_ff  <= 8'd80;
         reply_cmd_ff <= 8'd82;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            snfh_pkg::CSR_NODE_ADDRESS: node_ff      <= csr_wdata[6:0];
            snfh_pkg::CSR_START_CODE:   start_ff     <= csr_wdata;
            snfh_pkg::CSR_END_CODE:     end_ff       <= csr_wdata;
            snfh_pkg::CSR_ESCAPE_CODE:  esc_ff       <= csr_wdata;
            snfh_pkg::CSR_SET_CMD:      set_cmd_ff   <= csr_wdata;
            snfh_pkg::CSR_POLL_CMD:     poll_cmd_ff  <= csr_wdata;
            snfh_pkg::CSR_REPLY_CMD:    reply_cmd_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // frame parser for one received byte
   always_comb begin
      mode_in    = mode_ff;
      rcv_idx_in = rcv_idx_ff;
      ev_set     = 1'b0;
      ev_poll    = 1'b0;
      out_wr_en  = 1'b0;
      out_wr_addr = rcv_idx_ff[RX_AW-1:0];
      unique case (mode_ff)
         snfh_pkg::PM_PRE1: begin
            rcv_idx_in = '0;
            if (req_data_byte == snfh_pkg::PREAMBLE_BYTE) mode_in = snfh_pkg::PM_PRE2;
         end
         snfh_pkg::PM_PRE2: begin
            mode_in = (req_data_byte == snfh_pkg::PREAMBLE_BYTE) ?
                      snfh_pkg::PM_PRE3 : snfh_pkg::PM_PRE1;
         end
         snfh_pkg::PM_PRE3: begin
            mode_in = (req_data_byte == start_ff) ? snfh_pkg::PM_ADDR : snfh_pkg::PM_PRE1;
         end
         snfh_pkg::PM_ADDR: begin
            if (req_data_byte == addr_char) mode_in = snfh_pkg::PM_CMD;
            else if (req_data_byte >= snfh_pkg::ADDR_BASE) mode_in = snfh_pkg::PM_SKIPCMD;
            else mode_in = snfh_pkg::PM_PRE1;
         end
         snfh_pkg::PM_CMD: begin
            if (req_data_byte == set_cmd_ff) begin
               mode_in = snfh_pkg::PM_DATA;
            end else if (req_data_byte == poll_cmd_ff) begin
               mode_in = snfh_pkg::PM_PRE1;
               ev_poll = 1'b1;
            end else begin
               mode_in = snfh_pkg::PM_AFTER_OTHER;
            end
         end
         snfh_pkg::PM_SKIPCMD: mode_in = snfh_pkg::PM_SKIP;
         snfh_pkg::PM_DATA: begin
            if (req_data_byte == esc_ff) begin
               mode_in = snfh_pkg::PM_DATA_ESC;
            end else if (req_data_byte == end_ff) begin
               mode_in = snfh_pkg::PM_PRE1;
               ev_set  = 1'b1;
            end else if (rcv_idx_ff < RI_LIMIT) begin
               out_wr_en  = 1'b1;
               rcv_idx_in = rcv_idx_ff + RI_W'(1);
            end
         end
         snfh_pkg::PM_DATA_ESC: begin
            if (rcv_idx_ff < RI_LIMIT) begin
               out_wr_en  = 1'b1;
               rcv_idx_in = rcv_idx_ff + RI_W'(1);
            end
            mode_in = snfh_pkg::PM_DATA;
         end
         snfh_pkg::PM_SKIP: begin
            if (req_data_byte == esc_ff) mode_in = snfh_pkg::PM_SKIP_ESC;
            else if (req_data_byte == end_ff) mode_in = snfh_pkg::PM_PRE1;
         end
         snfh_pkg::PM_SKIP_ESC: mode_in = snfh_pkg::PM_SKIP;
         default: mode_in = snfh_pkg::PM_PRE1;
      endcase
   end

   assign host_in_range = req_store_index < TX_LIMIT;

   // transaction sequencer
   always_comb begin
      seq_in      = seq_ff;
      hdr_in      = hdr_ff;
      tx_idx_in   = tx_idx_ff;
      esc_done_in = esc_done_ff;
      out_load    = 1'b0;
      out_kind    = snfh_pkg::KIND_TX_BYTE;
      out_byte    = 8'd0;
      out_acc     = 1'b0;
      out_last    = 1'b0;
      out_rd_en   = 1'b0;
      out_rd_addr = req_store_index[RX_AW-1:0];
      in_wr_en    = 1'b0;
      in_wr_addr  = req_store_index[TX_AW-1:0];
      in_rd_en    = 1'b0;
      in_rd_addr  = tx_idx_ff + TX_AW'(1);
      unique case (seq_ff)
         snfh_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (req_operation)
                  snfh_pkg::OP_RX_BYTE: begin
                     if (ev_poll) begin
                        seq_in = snfh_pkg::ST_HDR;
                        hdr_in = snfh_pkg::HDR_PRE1;
                     end else if (ev_set) begin
                        out_load = 1'b1;
                        out_kind = snfh_pkg::KIND_SET_EVENT;
                        out_last = 1'b1;
                     end
                  end
                  snfh_pkg::OP_HOST_WRITE: begin
                     in_wr_en = host_in_range;
                     out_load = 1'b1;
                     out_kind = snfh_pkg::KIND_WR_STATUS;
                     out_acc  = host_in_range;
                     out_last = 1'b1;
                  end
                  snfh_pkg::OP_HOST_READ: begin
                     out_rd_en = 1'b1;
                     seq_in    = snfh_pkg::ST_RDWAIT;
                  end
                  default: ;
               endcase
            end
         end
         snfh_pkg::ST_RDWAIT: begin
            if (out_free) begin
               out_load = 1'b1;
               out_kind = snfh_pkg::KIND_READ_DATA;
               out_byte = out_rd_ok_ff ? out_rd_ff : 8'd0;
               out_last = 1'b1;
               seq_in   = snfh_pkg::ST_IDLE;
            end
         end
         snfh_pkg::ST_HDR: begin
            case (hdr_ff)
               snfh_pkg::HDR_START: out_byte = start_ff;
               snfh_pkg::HDR_ADDR:  out_byte = addr_char;
               snfh_pkg::HDR_REPLY: out_byte = reply_cmd_ff;
               default:             out_byte = snfh_pkg::PREAMBLE_BYTE;
            endcase
            if (out_free) begin
               out_load = 1'b1;
               if (hdr_ff == snfh_pkg::HDR_REPLY) begin
                  // prefetch the first input store byte
                  in_rd_en    = 1'b1;
                  in_rd_addr  = '0;
                  tx_idx_in   = '0;
                  esc_done_in = 1'b0;
                  seq_in      = snfh_pkg::ST_DATA;
               end else begin
                  hdr_in = hdr_ff + snfh_pkg::HDR_W'(1);
               end
            end
         end
         snfh_pkg::ST_DATA: begin
            out_byte = need_esc ? esc_ff : tx_byte;
            if (out_free) begin
               out_load = 1'b1;
               if (need_esc) begin
                  esc_done_in = 1'b1;
               end else begin
                  esc_done_in = 1'b0;
                  if (tx_idx_ff == TX_LAST) begin
                     seq_in = snfh_pkg::ST_END;
                  end else begin
                     // fetch the next byte while this one goes out
                     in_rd_en  = 1'b1;
                     tx_idx_in = tx_idx_ff + TX_AW'(1);
                  end
               end
            end
         end
         snfh_pkg::ST_END: begin
            out_byte = end_ff;
            if (out_free) begin
               out_load = 1'b1;
               out_last = 1'b1;
               seq_in   = snfh_pkg::ST_IDLE;
            end
         end
         default: seq_in = snfh_pkg::ST_IDLE;
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff      <= snfh_pkg::ST_IDLE;
         mode_ff     <= snfh_pkg::PM_PRE1;
         rcv_idx_ff  <= '0;
         hdr_ff      <= snfh_pkg::HDR_PRE1;
         tx_idx_ff   <= '0;
         esc_done_ff <= 1'b0;
      end else begin
         seq_ff      <= seq_in;
         hdr_ff      <= hdr_in;
         tx_idx_ff   <= tx_idx_in;
         esc_done_ff <= esc_done_in;
         if (req_fire && (req_operation == snfh_pkg::OP_RX_BYTE)) begin
            mode_ff    <= mode_in;
            rcv_idx_ff <= rcv_idx_in;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_kind_ff <= out_kind;
         rsp_byte_ff <= out_byte;
         rsp_acc_ff  <= out_acc;
         rsp_last_ff <= out_last;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_kind    = rsp_kind_ff;
   assign rsp_result_byte    = rsp_byte_ff;
   assign rsp_write_accepted = rsp_acc_ff;
   assign rsp_last_of_run    = rsp_last_ff;

   // per-entry written flags stand in for the all-zero reset contents
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= '0;
         in_vld_ff  <= '0;
      end else begin
         if (req_fire && (req_operation == snfh_pkg::OP_RX_BYTE) && out_wr_en)
            out_vld_ff[out_wr_addr] <= 1'b1;
         if (in_wr_en) in_vld_ff[in_wr_addr] <= 1'b1;
      end
   end

   // output store memory
   always_ff @(posedge clock) begin
      if (req_fire && (req_operation == snfh_pkg::OP_RX_BYTE) && out_wr_en)
         out_mem[out_wr_addr] <= req_data_byte;
      if (out_rd_en) begin
         out_rd_ff    <= out_mem[out_rd_addr];
         out_rd_ok_ff <= out_vld_ff[out_rd_addr] && (req_store_index < RX_LIMIT);
      end
   end

   // input store memory
   always_ff @(posedge clock) begin
      if (in_wr_en) in_mem[in_wr_addr] <= req_data_byte;
      if (in_rd_en) begin
         in_rd_ff    <= in_mem[in_rd_addr];
         in_rd_ok_ff <= in_vld_ff[in_rd_addr];
      end
   end

`ifndef SYNTHESIS
   // a loaded result is never overwritten before it is taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_load |-> out_free)
      else $error("result register overwritten while stalled");

   // receive index never passes the output store depth
   a_rcv_bound: assert property (@(posedge clock) disable iff (reset)
      rcv_idx_ff <= RI_LIMIT)
      else $error("receive index out of range");

   // host read goes through the memory wait state
   a_read_wait: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_operation == snfh_pkg::OP_HOST_READ)) |=>
      (seq_ff == snfh_pkg::ST_RDWAIT))
      else $error("host read did not wait for memory");

   // end code follows the data phase only
   a_end_order: assert property (@(posedge clock) disable iff (reset)
      ((seq_ff == snfh_pkg::ST_END) && !$past(reset) &&
       ($past(seq_ff) != snfh_pkg::ST_END)) |-> ($past(seq_ff) == snfh_pkg::ST_DATA))
      else $error("reply end reached out of order");

   // header and data reply results never close the run
   a_reply_last: assert property (@(posedge clock) disable iff (reset)
      (out_load && (seq_ff == snfh_pkg::ST_HDR || seq_ff == snfh_pkg::ST_DATA)) |->
      !out_last)
      else $error("reply run closed early");
`endif

endmodule
